@@ rtl/assert_macros.svh @@
// assertion macros used by nearest_button_match.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define NBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define NBM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/nbm_pkg.sv @@
// shared constants, payload types and helper types of the button matcher
package nbm_pkg;

  // table and coordinate sizing
  localparam int MAX_BUTTONS = 64;
  localparam int COORD_BITS  = 16;
  localparam int IDX_BITS    = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam int SCAN_BITS   = $clog2(MAX_BUTTONS + 1);

  // fixed field widths
  localparam int FIELD_COORD_BITS = 16;
  localparam int INDEX_FIELD_BITS = 6;
  localparam int ZONE_BITS        = 8;
  localparam int MAXD_BITS        = 17;
  localparam int ACT_BITS         = 7;
  localparam int CFG_DATA_BITS    = 17;

  // distance unit operand and result widths
  localparam int OP_BITS   = (COORD_BITS > MAXD_BITS) ? COORD_BITS : MAXD_BITS;
  localparam int SQ_BITS   = 2 * OP_BITS;
  localparam int DIST_BITS = SQ_BITS + 1;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_MAX_DISTANCE   = 1'b0,
    CFG_ACTIVE_BUTTONS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                               mode;
    logic [INDEX_FIELD_BITS-1:0]        entry_index;
    logic                               entry_left_eye;
    logic signed [ZONE_BITS-1:0]        entry_zone;
    logic [FIELD_COORD_BITS-1:0]        entry_x;
    logic [FIELD_COORD_BITS-1:0]        entry_y;
    logic                               fingertip_valid;
    logic [FIELD_COORD_BITS-1:0]        fingertip_x;
    logic [FIELD_COORD_BITS-1:0]        fingertip_y;
    logic                               query_left_eye;
    logic signed [ZONE_BITS-1:0]        query_zone;
  } in_item_t;

  typedef struct packed {
    logic                               matched;
    logic [INDEX_FIELD_BITS-1:0]        button_index;
    logic [FIELD_COORD_BITS-1:0]        echo_x;
    logic [FIELD_COORD_BITS-1:0]        echo_y;
    logic                               echo_left_eye;
  } out_item_t;

  // one stored button
  typedef struct packed {
    logic                               left_eye;
    logic signed [ZONE_BITS-1:0]        zone;
    logic [COORD_BITS-1:0]              x;
    logic [COORD_BITS-1:0]              y;
  } button_t;

  // side info carried along the distance pipeline
  typedef struct packed {
    logic                               is_limit;
    logic                               eye_ok;
    logic                               zone_ok;
    logic [IDX_BITS-1:0]                idx;
  } dist_tag_t;

  typedef struct packed {
    logic                               valid;
    dist_tag_t                          tag;
    logic [DIST_BITS-1:0]               sq_dist;
  } dist_res_t;

  typedef struct packed {
    logic                               matched;
    logic [IDX_BITS-1:0]                idx;
  } match_t;

endpackage

@@ rtl/nbm_table.sv @@
// button table memory: one write port, one registered read port
module nbm_table (
  input  logic                         clk,
  input  logic                         we,
  input  logic [nbm_pkg::IDX_BITS-1:0] waddr,
  input  nbm_pkg::button_t             wdata,
  input  logic [nbm_pkg::IDX_BITS-1:0] raddr,
  output nbm_pkg::button_t             rdata
);
  import nbm_pkg::*;

  button_t mem_r [MAX_BUTTONS];
  button_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/nbm_dist_unit.sv @@
// shared distance unit: |ax-bx|^2 + |ay-by|^2 over three register stages
module nbm_dist_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  nbm_pkg::dist_tag_t          in_tag,
  input  logic [nbm_pkg::OP_BITS-1:0] ax,
  input  logic [nbm_pkg::OP_BITS-1:0] bx,
  input  logic [nbm_pkg::OP_BITS-1:0] ay,
  input  logic [nbm_pkg::OP_BITS-1:0] by,
  output logic                        busy,
  output nbm_pkg::dist_res_t          res
);
  import nbm_pkg::*;

  logic                 va_r, vb_r, vc_r;
  dist_tag_t            ta_r, tb_r, tc_r;
  logic [OP_BITS-1:0]   dx_r, dy_r;
  logic [OP_BITS-1:0]   dx_nxt, dy_nxt;
  logic [SQ_BITS-1:0]   sqx_r, sqy_r;
  logic [SQ_BITS-1:0]   sqx_nxt, sqy_nxt;
  logic [DIST_BITS-1:0] sum_r;
  logic [DIST_BITS-1:0] sum_nxt;

  // stage logic: absolute differences, squares, sum
  always_comb begin
    dx_nxt  = (ax >= bx) ? (ax - bx) : (bx - ax);
    dy_nxt  = (ay >= by) ? (ay - by) : (by - ay);
    sqx_nxt = SQ_BITS'(dx_r) * SQ_BITS'(dx_r);
    sqy_nxt = SQ_BITS'(dy_r) * SQ_BITS'(dy_r);
    sum_nxt = DIST_BITS'(sqx_r) + DIST_BITS'(sqy_r);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= in_vld;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    ta_r  <= in_tag;
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    tb_r  <= ta_r;
    sqx_r <= sqx_nxt;
    sqy_r <= sqy_nxt;
    tc_r  <= tb_r;
    sum_r <= sum_nxt;
  end

  assign busy        = va_r | vb_r | vc_r;
  assign res.valid   = vc_r;
  assign res.tag     = tc_r;
  assign res.sq_dist = sum_r;

endmodule

@@ rtl/nbm_best.sv @@
// nearest candidate tracking for the zone pass and the any-zone pass
module nbm_best (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clear,
  input  nbm_pkg::dist_res_t res,
  output nbm_pkg::match_t    match
);
  import nbm_pkg::*;

  logic                 z_found_r, z_found_nxt;
  logic [DIST_BITS-1:0] z_dist_r, z_dist_nxt;
  logic [IDX_BITS-1:0]  z_idx_r, z_idx_nxt;
  logic                 a_found_r, a_found_nxt;
  logic [DIST_BITS-1:0] a_dist_r, a_dist_nxt;
  logic [IDX_BITS-1:0]  a_idx_r, a_idx_nxt;
  logic [DIST_BITS-1:0] lim_r, lim_nxt;
  logic                 z_hit, a_hit;

  // strict less keeps the lower index on ties
  always_comb begin
    z_found_nxt = z_found_r;
    z_dist_nxt  = z_dist_r;
    z_idx_nxt   = z_idx_r;
    a_found_nxt = a_found_r;
    a_dist_nxt  = a_dist_r;
    a_idx_nxt   = a_idx_r;
    lim_nxt     = lim_r;
    if (clear) begin
      z_found_nxt = 1'b0;
      a_found_nxt = 1'b0;
    end else if (res.valid) begin
      if (res.tag.is_limit) begin
        lim_nxt = res.sq_dist;
      end else if (res.tag.eye_ok) begin
        if (!a_found_r || (res.sq_dist < a_dist_r)) begin
          a_found_nxt = 1'b1;
          a_dist_nxt  = res.sq_dist;
          a_idx_nxt   = res.tag.idx;
        end
        if (res.tag.zone_ok && (!z_found_r || (res.sq_dist < z_dist_r))) begin
          z_found_nxt = 1'b1;
          z_dist_nxt  = res.sq_dist;
          z_idx_nxt   = res.tag.idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_found_r <= 1'b0;
      a_found_r <= 1'b0;
    end else begin
      z_found_r <= z_found_nxt;
      a_found_r <= a_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_dist_r <= z_dist_nxt;
    z_idx_r  <= z_idx_nxt;
    a_dist_r <= a_dist_nxt;
    a_idx_r  <= a_idx_nxt;
    lim_r    <= lim_nxt;
  end

  // zone pass wins when in limit, else fall back to the any-zone pass
  always_comb begin
    z_hit         = z_found_r && (z_dist_r <= lim_r);
    a_hit         = a_found_r && (a_dist_r <= lim_r);
    match.matched = z_hit | a_hit;
    match.idx     = z_hit ? z_idx_r : a_idx_r;
  end

endmodule

@@ rtl/nearest_button_match.sv @@
// Nearest button lookup: a write item updates the table and gives no result.
// A query with a valid fingertip feeds the limit, scans the active entries, one entry
// per cycle through the shared distance unit, drains and then loads its result;
// an invalid fingertip skips the search and loads an unmatched result.
// Input stalls meanwhile: no new item is taken until the result is loaded.
// Reset clears control state and both config registers; table stays undefined.
`include "assert_macros.svh"

module nearest_button_match (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  nbm_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output nbm_pkg::out_item_t               out_item,
  input  logic                             cfg_we,
  input  nbm_pkg::cfg_reg_t                cfg_index,
  input  logic [nbm_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import nbm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LIMIT = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [MAXD_BITS-1:0]        max_distance_r;
  logic [ACT_BITS-1:0]         active_buttons_r;
  logic [FIELD_COORD_BITS-1:0] echo_x_r, echo_y_r;
  logic                        qeye_r;
  logic signed [ZONE_BITS-1:0] qzone_r;
  logic [SCAN_BITS-1:0]        n_r, n_nxt;
  logic [SCAN_BITS-1:0]        cnt_r, cnt_nxt;
  logic                        rd_vld_r;
  logic [IDX_BITS-1:0]         rd_idx_r;
  logic                        out_valid_r, out_valid_nxt;
  out_item_t                   out_item_r;
  logic                        in_xfer, query_xfer, out_load;
  logic                        tbl_we;
  button_t                     tbl_wdata, tbl_rdata;
  logic [IDX_BITS-1:0]         rd_addr;
  logic                        du_vld, du_busy;
  dist_tag_t                   du_tag;
  logic [OP_BITS-1:0]          du_ax, du_bx, du_ay, du_by;
  dist_res_t                   du_res;
  match_t                      match;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign query_xfer = in_xfer && (in_item.mode == MODE_QUERY);
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_distance_r   <= '0;
      active_buttons_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_DISTANCE:   max_distance_r   <= cfg_wdata;
        CFG_ACTIVE_BUTTONS: active_buttons_r <= cfg_wdata[ACT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // table write on a write transfer; slots past the table are dropped
  assign tbl_we = in_xfer && (in_item.mode == MODE_WRITE)
                  && (32'(in_item.entry_index) < 32'(MAX_BUTTONS));
  always_comb begin
    tbl_wdata.left_eye = in_item.entry_left_eye;
    tbl_wdata.zone     = in_item.entry_zone;
    tbl_wdata.x        = COORD_BITS'(in_item.entry_x);
    tbl_wdata.y        = COORD_BITS'(in_item.entry_y);
  end

  assign rd_addr = cnt_r[IDX_BITS-1:0];

  nbm_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (IDX_BITS'(in_item.entry_index)),
    .wdata (tbl_wdata),
    .raddr (rd_addr),
    .rdata (tbl_rdata)
  );

  // search length saturates at the table size
  assign n_nxt = (32'(active_buttons_r) > 32'(MAX_BUTTONS)) ? SCAN_BITS'(MAX_BUTTONS)
                                                          : SCAN_BITS'(active_buttons_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (query_xfer) begin
          state_nxt = in_item.fingertip_valid ? ST_LIMIT : ST_DONE;
        end
      end
      ST_LIMIT: begin
        state_nxt = (n_r != '0) ? ST_SCAN : ST_DRAIN;
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + SCAN_BITS'(1);
        if ((cnt_r + SCAN_BITS'(1)) == n_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !du_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= (state_r == ST_SCAN);
    end
  end

  // query fields held for the whole search
  always_ff @(posedge clk) begin
    rd_idx_r <= rd_addr;
    if (query_xfer) begin
      echo_x_r <= in_item.fingertip_x;
      echo_y_r <= in_item.fingertip_y;
      qeye_r   <= in_item.query_left_eye;
      qzone_r  <= in_item.query_zone;
      n_r      <= n_nxt;
    end
  end

  // distance unit feed: the limit first, then one table entry per cycle
  always_comb begin
    du_tag.is_limit = (state_r == ST_LIMIT);
    du_tag.eye_ok   = (tbl_rdata.left_eye == qeye_r);
    du_tag.zone_ok  = qzone_r[ZONE_BITS-1] || tbl_rdata.zone[ZONE_BITS-1]
                      || (tbl_rdata.zone == qzone_r);
    du_tag.idx      = rd_idx_r;
    if (state_r == ST_LIMIT) begin
      du_vld = 1'b1;
      du_ax  = OP_BITS'(max_distance_r);
      du_bx  = '0;
      du_ay  = '0;
      du_by  = '0;
    end else begin
      du_vld = rd_vld_r;
      du_ax  = OP_BITS'(tbl_rdata.x);
      du_bx  = OP_BITS'(COORD_BITS'(echo_x_r));
      du_ay  = OP_BITS'(tbl_rdata.y);
      du_by  = OP_BITS'(COORD_BITS'(echo_y_r));
    end
  end

  nbm_dist_unit u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (du_vld),
    .in_tag (du_tag),
    .ax     (du_ax),
    .bx     (du_bx),
    .ay     (du_ay),
    .by     (du_by),
    .busy   (du_busy),
    .res    (du_res)
  );

  nbm_best u_best (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (query_xfer),
    .res   (du_res),
    .match (match)
  );

  // result register, freed by an output transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r.matched       <= match.matched;
      out_item_r.button_index  <= match.matched ? INDEX_FIELD_BITS'(match.idx) : '0;
      out_item_r.echo_x        <= echo_x_r;
      out_item_r.echo_y        <= echo_y_r;
      out_item_r.echo_left_eye <= qeye_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  `NBM_ASSERT(a_load_from_done, $rose(out_valid_r) |-> $past(state_r == ST_DONE), "result loaded outside done")
  `NBM_ASSERT(a_unmatched_zero, (out_valid_r && !out_item_r.matched) |-> (out_item_r.button_index == '0), "unmatched result carries an index")
  `NBM_ASSERT(a_scan_bound, (state_r == ST_SCAN) |-> (cnt_r < n_r), "scan ran past the active entries")
  `NBM_ASSERT_NEVER(a_idle_drained, (state_r == ST_IDLE) && (rd_vld_r || du_busy), "search pipeline busy while idle")

endmodule

@@ tb/nearest_button_match_test.sv @@
// self-checking testbench for the nearest button matcher with its own search predictor
module nearest_button_match_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nbm_pkg::*;

  localparam int DRAIN_CYCLES = 100;
  localparam int PHASES = 14;
  localparam int ITEMS_PER_PHASE = 125;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_index = CFG_MAX_DISTANCE;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // predictor state: button table copy and register copies
  button_t shelf [MAX_BUTTONS];
  logic [MAXD_BITS-1:0] reach_reg = '0;
  logic [ACT_BITS-1:0] count_reg = '0;

  out_item_t pending_matches [$];
  int mismatches = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  nearest_button_match dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // nearest same-eye button within reach, -1 if none
  function automatic int nearest_in_reach(in_item_t q, bit zone_gate);
    longint unsigned lim, reach2, best, bx, by, fx, fy, dx, dy, d2;
    int n;
    int best_idx;
    lim = 64'(reach_reg);
    reach2 = lim * lim;
    fx = 64'(q.fingertip_x);
    fy = 64'(q.fingertip_y);
    n = (int'(count_reg) > MAX_BUTTONS) ? MAX_BUTTONS : int'(count_reg);
    best = 0;
    best_idx = -1;
    for (int i = 0; i < n; i++) begin
      if (shelf[i].left_eye != q.query_left_eye) continue;
      // a negative zone on either side matches any zone
      if (zone_gate && !q.query_zone[7] && !shelf[i].zone[7] && shelf[i].zone != q.query_zone)
        continue;
      bx = 64'(shelf[i].x);
      by = 64'(shelf[i].y);
      dx = (bx >= fx) ? bx - fx : fx - bx;
      dy = (by >= fy) ? by - fy : fy - by;
      d2 = dx * dx + dy * dy;
      // strict compare keeps the lower index on ties
      if (best_idx < 0 || d2 < best) begin
        best = d2;
        best_idx = i;
      end
    end
    if (best_idx >= 0 && best <= reach2) return best_idx;
    return -1;
  endfunction

  // expected result of one query: zoned pass first, then zone-blind pass
  function automatic out_item_t predict_match(in_item_t q);
    out_item_t r;
    int hit;
    r = '0;
    r.echo_x = q.fingertip_x;
    r.echo_y = q.fingertip_y;
    r.echo_left_eye = q.query_left_eye;
    if (q.fingertip_valid) begin
      hit = nearest_in_reach(q, 1'b1);
      if (hit < 0) hit = nearest_in_reach(q, 1'b0);
      if (hit >= 0) begin
        r.matched = 1'b1;
        r.button_index = hit[INDEX_FIELD_BITS-1:0];
      end
    end
    return r;
  endfunction

  // zones cluster on a few values so zone agreement happens often
  function automatic logic signed [ZONE_BITS-1:0] rand_zone();
    logic signed [ZONE_BITS-1:0] z;
    case ($urandom_range(0, 5))
      0, 1: begin
        z = -8'sd1;
      end
      2, 3, 4: begin
        z = 8'($urandom_range(0, 3));
      end
      default: begin
        z = 8'($urandom_range(0, 127));
      end
    endcase
    return z;
  endfunction

  function automatic logic [15:0] nudge(logic [15:0] c, int span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // unused fields carry random noise
  function automatic in_item_t make_entry(logic [5:0] slot, bit eye,
                                          logic signed [7:0] zone, logic [15:0] x, logic [15:0] y);
    in_item_t it;
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    it = noise[$bits(in_item_t)-1:0];
    it.mode = MODE_WRITE;
    it.entry_index = slot;
    it.entry_left_eye = eye;
    it.entry_zone = zone;
    it.entry_x = x;
    it.entry_y = y;
    return it;
  endfunction

  function automatic in_item_t make_query(bit valid, logic [15:0] fx, logic [15:0] fy, bit eye,
                                          logic signed [7:0] zone);
    in_item_t it;
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    it = noise[$bits(in_item_t)-1:0];
    it.mode = MODE_QUERY;
    it.fingertip_valid = valid;
    it.fingertip_x = fx;
    it.fingertip_y = fy;
    it.query_left_eye = eye;
    it.query_zone = zone;
    return it;
  endfunction

  // one input transfer, then update the table copy or queue the expected match
  task automatic send_item(in_item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    gap = quiet ? 0 : int'($urandom_range(0, 13));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    if (it.mode == MODE_WRITE) begin
      shelf[it.entry_index].left_eye = it.entry_left_eye;
      shelf[it.entry_index].zone = it.entry_zone;
      shelf[it.entry_index].x = it.entry_x;
      shelf[it.entry_index].y = it.entry_y;
    end else begin
      pending_matches.push_back(predict_match(it));
    end
  endtask

  // drop valid, let every result arrive, then cover a trailing write or query
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [MAXD_BITS-1:0] reach, logic [ACT_BITS-1:0] count);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_DISTANCE;
    cfg_wdata <= reach;
    @(posedge clk);
    cfg_index <= CFG_ACTIVE_BUTTONS;
    cfg_wdata <= CFG_DATA_BITS'(count);
    @(posedge clk);
    cfg_we <= 1'b0;
    reach_reg = reach;
    count_reg = count;
  endtask

  // queries with no active entries never match
  task automatic test_empty_table();
    send_item(make_query(1'b1, 16'h0000, 16'h0000, 1'b0, 8'sd0));
    send_item(make_query(1'b0, 16'hFFFF, 16'hFFFF, 1'b1, -8'sd1));
    set_config(17'd92682, 7'd0);
    send_item(make_query(1'b1, 16'hFFFF, 16'h0000, 1'b1, 8'sd127));
  endtask

  // every slot gets written before any search can reach it
  task automatic test_table_load();
    for (int i = 0; i < MAX_BUTTONS; i++) begin
      if (i == 0)
        send_item(make_entry(6'd0, 1'b0, -8'sd1, 16'h0000, 16'h0000));
      else if (i == MAX_BUTTONS - 1)
        send_item(make_entry(6'd63, 1'b1, 8'sd127, 16'hFFFF, 16'hFFFF));
      else
        send_item(make_entry(6'(i), bit'($urandom_range(0, 1)), rand_zone(),
                             16'($urandom), 16'($urandom)));
    end
  endtask

  // zone preference, fallback, ties, limits, eye filter and saturation
  task automatic test_directed_search();
    send_item(make_entry(6'd0, 1'b1, 8'sd5, 16'd1000, 16'd1000));
    send_item(make_entry(6'd1, 1'b1, 8'sd6, 16'd1000, 16'd1000));
    send_item(make_entry(6'd2, 1'b0, -8'sd1, 16'h0000, 16'h0000));
    send_item(make_entry(6'd3, 1'b0, 8'sd127, 16'hFFFF, 16'hFFFF));
    send_item(make_entry(6'd4, 1'b1, 8'sd5, 16'd1003, 16'd1004));
    set_config(17'd5, 7'd5);
    send_item(make_query(1'b1, 16'd1000, 16'd1000, 1'b1, 8'sd6));
    send_item(make_query(1'b1, 16'd1000, 16'd1000, 1'b1, 8'sd7));
    send_item(make_query(1'b1, 16'd1000, 16'd1000, 1'b1, -8'sd1));
    // exactly on the limit, then just past it
    send_item(make_query(1'b1, 16'd1003, 16'd1004, 1'b1, 8'sd6));
    send_item(make_query(1'b1, 16'd1004, 16'd1004, 1'b1, 8'sd6));
    send_item(make_query(1'b1, 16'h0000, 16'h0000, 1'b0, 8'sd127));
    send_item(make_query(1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 8'sd3));
    send_item(make_query(1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 8'sd5));
    // count beyond the table size saturates
    set_config(17'd92682, 7'd127);
    send_item(make_query(1'b1, 16'h0000, 16'h0000, 1'b0, 8'sd127));
    send_item(make_query(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, -8'sd1));
    set_config(17'd0, 7'd64);
    send_item(make_query(1'b1, 16'h0000, 16'h0000, 1'b0, 8'sd3));
    send_item(make_query(1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 8'sd3));
    set_config(17'h1FFFF, 7'd1);
    send_item(make_query(1'b1, 16'hFFFF, 16'h0000, 1'b1, 8'sd0));
    send_item(make_query(1'b1, 16'hFFFF, 16'h0000, 1'b0, 8'sd0));
    send_item(make_query(1'b0, 16'h1234, 16'h8765, 1'b1, 8'sd0));
  endtask

  // phases of random settings; queries mostly land near an active button
  task automatic test_random_search();
    logic [MAXD_BITS-1:0] reach;
    logic [ACT_BITS-1:0] count;
    logic signed [ZONE_BITS-1:0] zone;
    in_item_t it;
    int n_act;
    int pick;
    int other;
    int span;
    bit eye;
    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0: reach = '0;
        1: reach = 17'($urandom_range(0, 16));
        2: reach = 17'($urandom_range(0, 2000));
        3: reach = 17'($urandom_range(0, 20000));
        4: reach = 17'd92682;
        default: reach = 17'h1FFFF;
      endcase
      case ($urandom_range(0, 7))
        0: count = '0;
        1: count = 7'd1;
        2, 3, 4: count = 7'($urandom_range(1, 64));
        5: count = 7'd64;
        6: count = 7'($urandom_range(65, 127));
        default: count = 7'($urandom_range(0, 127));
      endcase
      set_config(reach, count);
      n_act = (int'(count) > MAX_BUTTONS) ? MAX_BUTTONS : int'(count);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 9) < 2) begin
          // table rewrite, sometimes onto another button's spot to force ties
          pick = $urandom_range(0, MAX_BUTTONS - 1);
          other = $urandom_range(0, MAX_BUTTONS - 1);
          if ($urandom_range(0, 3) == 0)
            it = make_entry(6'(pick), bit'($urandom_range(0, 1)), rand_zone(),
                            shelf[other].x, shelf[other].y);
          else
            it = make_entry(6'(pick), bit'($urandom_range(0, 1)), rand_zone(),
                            16'($urandom), 16'($urandom));
        end else if (n_act > 0 && $urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, n_act - 1);
          case ($urandom_range(0, 3))
            0: span = 0;
            1: span = 4;
            2: span = int'(reach) + int'(reach) / 8 + 2;
            default: span = 65535;
          endcase
          if (span > 65535) span = 65535;
          eye = ($urandom_range(0, 6) == 0) ? !shelf[pick].left_eye : shelf[pick].left_eye;
          zone = $urandom_range(0, 1) ? shelf[pick].zone : rand_zone();
          it = make_query($urandom_range(0, 9) != 0, nudge(shelf[pick].x, span),
                          nudge(shelf[pick].y, span), eye, zone);
        end else begin
          it = make_query($urandom_range(0, 9) != 0, 16'($urandom), 16'($urandom),
                          bit'($urandom_range(0, 1)), rand_zone());
        end
        send_item(it);
      end
    end
  endtask

  // result side: random stall per result, compare against the oldest expectation
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_matches.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: expected none, actual %h", $time, out_item);
        end else begin
          want = pending_matches.pop_front();
          if (out_item !== want) begin
            mismatches++;
            $display("%0t result mismatch: expected matched=%0d index=%0d x=%h y=%h eye=%0d, ",
                     $time, want.matched, want.button_index, want.echo_x, want.echo_y,
                     want.echo_left_eye,
                     "actual matched=%0d index=%0d x=%h y=%h eye=%0d",
                     out_item.matched, out_item.button_index,
                     out_item.echo_x, out_item.echo_y, out_item.echo_left_eye);
          end
        end
        stall_left = quiet ? 0 : int'($urandom_range(0, 13));
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // run ceiling
  initial begin : watchdog
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : main_sequence
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_table_load();
    test_directed_search();
    test_random_search();
    wait_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/nbm_pkg.sv
rtl/nbm_table.sv
rtl/nbm_dist_unit.sv
rtl/nbm_best.sv
rtl/nearest_button_match.sv
tb/nearest_button_match_test.sv
